[sv/ijsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ijsd_pkg
// Shared types, constants and byte mapping functions for the ISO-2022-JP-3
// to Shift_JIS decoder.
// ----------------------------------------------------------------------------
package ijsd_pkg;

  // Charset modes
  localparam logic [2:0] MODE_ASCII = 3'd0;
  localparam logic [2:0] MODE_ROMAN = 3'd1;
  localparam logic [2:0] MODE_KANA  = 3'd2;
  localparam logic [2:0] MODE_MEN1  = 3'd3;
  localparam logic [2:0] MODE_MEN2  = 3'd4;
  localparam logic [2:0] MODE_X0208 = 3'd5;
  localparam logic [2:0] MODE_X0212 = 3'd6;

  // Special bytes
  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_SI     = 8'h0f;
  localparam logic [7:0] BYTE_SO     = 8'h0e;
  localparam logic [7:0] BYTE_QMARK  = 8'h3f;
  localparam logic [7:0] BYTE_DOLLAR = 8'h24;
  localparam logic [7:0] BYTE_LPAREN = 8'h28;
  localparam logic [7:0] BYTE_AT     = 8'h40;
  localparam logic [7:0] BYTE_B      = 8'h42;
  localparam logic [7:0] BYTE_D      = 8'h44;
  localparam logic [7:0] BYTE_I      = 8'h49;
  localparam logic [7:0] BYTE_J      = 8'h4a;
  localparam logic [7:0] BYTE_O      = 8'h4f;
  localparam logic [7:0] BYTE_P      = 8'h50;
  localparam logic [7:0] PRINT_LO    = 8'h21;
  localparam logic [7:0] PRINT_HI    = 8'h7e;
  localparam logic [7:0] KANA_BIT    = 8'h80;

  // Arithmetic mapping constants
  localparam logic [7:0] ROW_OFS_A   = 8'h5e;
  localparam logic [7:0] ROW_OFS_B   = 8'h58;
  localparam logic [7:0] ROW_OFS_C   = 8'h1a;
  localparam logic [7:0] TRAIL_ODD   = 8'h1f;
  localparam logic [7:0] TRAIL_EVEN  = 8'h7d;
  localparam logic [7:0] TRAIL_GAP   = 8'h7f;
  localparam logic [7:0] LEAD_BASE   = 8'h81;
  localparam logic [7:0] LEAD_LIMIT  = 8'h9f;
  localparam logic [7:0] LEAD_GAP    = 8'h40;

  localparam int MAX_RES     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] esc_cnt;
    logic [7:0] hold1;
    logic [7:0] hold2;
    logic [7:0] lead;
    logic       lead_v;
  } dec_state_t;

  // All result bytes caused by one input beat.
  typedef struct packed {
    logic [1:0]                last_idx;
    logic [MAX_RES-1:0][7:0]   bytes;
    logic [MAX_RES-1:0]        raw;
  } run_t;

  typedef struct packed {
    dec_state_t st;
    logic [2:0] n;
    run_t       run;
  } work_t;

  function automatic work_t put_byte(work_t w, logic [7:0] b, logic raw);
    work_t r;
    r = w;
    if (w.n < 3'(MAX_RES)) begin
      r.run.bytes[w.n[1:0]] = b;
      r.run.raw[w.n[1:0]]   = raw;
      r.n                   = w.n + 3'd1;
    end
    return r;
  endfunction

  // Returns {valid, sjis_lead, sjis_trail}.
  function automatic logic [16:0] map_pair(logic [7:0] row, logic [7:0] col,
                                           logic plane2);
    logic [7:0] hi;
    logic [7:0] lo;
    logic       ok;
    hi = row;
    lo = col;
    ok = (col >= PRINT_LO) && (col <= PRINT_HI) &&
         (row >= PRINT_LO) && (row <= PRINT_HI);
    if (plane2) begin
      if (hi == 8'h21 || (hi >= 8'h23 && hi <= 8'h25)) begin
        hi = hi + ROW_OFS_A;
      end else if (hi == 8'h28 || (hi >= 8'h2c && hi <= 8'h2f)) begin
        hi = hi + ROW_OFS_B;
      end else if (hi >= 8'h6e) begin
        hi = hi + ROW_OFS_C;
      end else begin
        ok = 1'b0;
      end
    end
    lo = lo + (hi[0] ? TRAIL_ODD : TRAIL_EVEN);
    if (lo >= TRAIL_GAP) begin
      lo = lo + 8'd1;
    end
    hi = ((hi - PRINT_LO) >> 1) + LEAD_BASE;
    if (hi > LEAD_LIMIT) begin
      hi = hi + LEAD_GAP;
    end
    return {ok, hi, lo};
  endfunction

  // Handles one data byte outside of escape processing.
  function automatic work_t take_byte(work_t w, logic [7:0] b);
    work_t       r;
    logic [16:0] code;
    logic        printable;
    r         = w;
    code      = map_pair(w.st.lead, b, w.st.mode == MODE_MEN2);
    printable = (b >= PRINT_LO) && (b <= PRINT_HI);
    priority if (w.st.lead_v) begin
      r.st.lead_v = 1'b0;
      if (w.st.mode == MODE_X0212) begin
        r = put_byte(r, w.st.lead, 1'b1);
        r = put_byte(r, b, 1'b1);
      end else if (!code[16]) begin
        r = put_byte(r, BYTE_QMARK, 1'b0);
      end else begin
        r = put_byte(r, code[15:8], 1'b0);
        r = put_byte(r, code[7:0], 1'b0);
      end
    end else if (b == BYTE_ESC) begin
      r.st.esc_cnt = 2'd1;
    end else if (b == BYTE_SI && w.st.mode == MODE_KANA) begin
      r.st.mode = MODE_ROMAN;
    end else if (b == BYTE_SO && w.st.mode == MODE_ROMAN) begin
      r.st.mode = MODE_KANA;
    end else if (printable && w.st.mode == MODE_KANA) begin
      r = put_byte(r, b | KANA_BIT, 1'b0);
    end else if (printable && w.st.mode >= MODE_MEN1 && w.st.mode <= MODE_X0212) begin
      r.st.lead   = b;
      r.st.lead_v = 1'b1;
    end else begin
      r = put_byte(r, b, 1'b0);
    end
    return r;
  endfunction

endpackage

[sv/ijsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ijsd_front
// Accepts input beats, tracks charset mode, escape and lead bytes, and
// pushes the result bytes of each beat into the run queue as one entry.
// ----------------------------------------------------------------------------
module ijsd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          push,
  output ijsd_pkg::run_t push_run,
  input  logic          q_full
);
  import ijsd_pkg::*;

  logic [2:0] mode_r;
  logic [1:0] esc_cnt_r;
  logic       lead_v_r;
  logic [7:0] hold1_r;
  logic [7:0] hold2_r;
  logic [7:0] lead_r;

  dec_state_t st_cur;
  dec_state_t st_nxt;
  work_t      w;
  logic       ext;
  logic [1:0] eos_cnt;
  logic [7:0] eos_h1;
  logic [7:0] eos_h2;
  logic       accept;

  assign st_cur = '{mode: mode_r, esc_cnt: esc_cnt_r, hold1: hold1_r, hold2: hold2_r,
                    lead: lead_r, lead_v: lead_v_r};

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;

  always_comb begin
    w       = '0;
    w.st    = st_cur;
    ext     = 1'b0;
    eos_cnt = 2'd0;
    eos_h1  = '0;
    eos_h2  = '0;
    if (esc_cnt_r != 2'd0) begin
      // Try to extend or complete the held escape sequence.
      if (esc_cnt_r == 2'd1) begin
        if (in_tdata == BYTE_DOLLAR || in_tdata == BYTE_LPAREN) begin
          w.st.hold1   = in_tdata;
          w.st.esc_cnt = 2'd2;
          ext          = 1'b1;
        end
      end else if (esc_cnt_r == 2'd2) begin
        if (hold1_r == BYTE_DOLLAR) begin
          if (in_tdata == BYTE_AT || in_tdata == BYTE_B) begin
            w.st.mode    = MODE_X0208;
            w.st.esc_cnt = 2'd0;
            ext          = 1'b1;
          end else if (in_tdata == BYTE_LPAREN) begin
            w.st.hold2   = in_tdata;
            w.st.esc_cnt = 2'd3;
            ext          = 1'b1;
          end
        end else if (hold1_r == BYTE_LPAREN) begin
          if (in_tdata == BYTE_B || in_tdata == BYTE_J || in_tdata == BYTE_I) begin
            w.st.mode    = (in_tdata == BYTE_B) ? MODE_ASCII :
                           (in_tdata == BYTE_J) ? MODE_ROMAN : MODE_KANA;
            w.st.esc_cnt = 2'd0;
            ext          = 1'b1;
          end
        end
      end else begin
        if (in_tdata == BYTE_O || in_tdata == BYTE_P || in_tdata == BYTE_D) begin
          w.st.mode    = (in_tdata == BYTE_O) ? MODE_MEN1 :
                         (in_tdata == BYTE_P) ? MODE_MEN2 : MODE_X0212;
          w.st.esc_cnt = 2'd0;
          ext          = 1'b1;
        end
      end
      // A failed sequence is replayed as data before the failing byte.
      if (!ext) begin
        w.st.esc_cnt = 2'd0;
        w = put_byte(w, BYTE_ESC, 1'b0);
        if (esc_cnt_r != 2'd1) begin
          w = take_byte(w, hold1_r);
        end
        if (esc_cnt_r == 2'd3) begin
          w = take_byte(w, hold2_r);
        end
        w = take_byte(w, in_tdata);
      end
    end else begin
      w = take_byte(w, in_tdata);
    end

    if (in_tlast) begin
      // Flush held escape bytes; a pending lead byte is dropped by the reset.
      eos_cnt = w.st.esc_cnt;
      eos_h1  = w.st.hold1;
      eos_h2  = w.st.hold2;
      w.st.esc_cnt = 2'd0;
      if (eos_cnt != 2'd0) begin
        w = put_byte(w, BYTE_ESC, 1'b0);
        if (eos_cnt != 2'd1) begin
          w = take_byte(w, eos_h1);
        end
        if (eos_cnt == 2'd3) begin
          w = take_byte(w, eos_h2);
        end
      end
      w.st.mode    = MODE_ASCII;
      w.st.esc_cnt = 2'd0;
      w.st.lead_v  = 1'b0;
    end
    st_nxt = w.st;
  end

  always_comb begin
    push_run          = w.run;
    push_run.last_idx = 2'(w.n - 3'd1);
  end

  assign push = accept && (w.n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ASCII;
      esc_cnt_r <= 2'd0;
      lead_v_r  <= 1'b0;
    end else if (accept) begin
      mode_r    <= st_nxt.mode;
      esc_cnt_r <= st_nxt.esc_cnt;
      lead_v_r  <= st_nxt.lead_v;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold1_r <= st_nxt.hold1;
      hold2_r <= st_nxt.hold2;
      lead_r  <= st_nxt.lead;
    end
  end

endmodule

[sv/ijsd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ijsd_fifo
// Short queue of result runs between the front and the back.
// ----------------------------------------------------------------------------
module ijsd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ijsd_pkg::run_t push_run,
  output logic           full,
  input  logic           pop,
  output ijsd_pkg::run_t head_run,
  output logic           empty
);
  import ijsd_pkg::*;

  run_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_run = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + (QPTR_W)'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + (QPTR_W)'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_run;
    end
  end

endmodule

[sv/ijsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ijsd_back
// Serializes queued runs into output beats, one byte per cycle while
// out_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module ijsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  ijsd_pkg::run_t head_run,
  input  logic           empty,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [0:0]     out_tuser,
  output logic           out_tlast
);
  import ijsd_pkg::*;

  logic [1:0] idx_r;
  logic       ov_r;
  logic [7:0] ob_r;
  logic       oraw_r;
  logic       olast_r;
  logic       ld;
  logic       at_end;

  assign ld     = !empty && (!ov_r || out_tready);
  assign at_end = (idx_r == head_run.last_idx);
  assign pop    = ld && at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else if (ld) begin
      ov_r  <= 1'b1;
      idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      ov_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ob_r    <= head_run.bytes[idx_r];
      oraw_r  <= head_run.raw[idx_r];
      olast_r <= at_end;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = ob_r;
  assign out_tuser[0] = oraw_r;
  assign out_tlast    = olast_r;

endmodule

[sv/iso2022jp3_to_sjis_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso2022jp3_to_sjis_decoder
// ISO-2022-JP-3 byte stream in, Shift_JIS-2004 byte stream out.
//
//   Channel  Direction  tdata             tuser          tlast
//   in_      slave      [7:0] in_byte     -              end_of_stream
//   out_     master     [7:0] out_byte    [0] raw_x0212  last_of_run
//
// One input byte is accepted per cycle while the run queue has room.
// Each input byte yields zero to four output bytes; the back end sends one
// byte per cycle while out_tready is high, so n results hold the back for n beats.
// A four-entry queue lets the front keep accepting while the output stalls.
// Reset is synchronous and returns the decoder to ASCII mode with the queue
// empty.
// ----------------------------------------------------------------------------
module iso2022jp3_to_sjis_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [0:0] out_tuser,  // [0] raw_x0212
  output logic       out_tlast
);
  import ijsd_pkg::*;

  logic push;
  logic q_full;
  logic pop;
  logic q_empty;
  run_t push_run;
  run_t head_run;

  ijsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_run  (push_run),
    .q_full    (q_full)
  );

  ijsd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .full     (q_full),
    .pop      (pop),
    .head_run (head_run),
    .empty    (q_empty)
  );

  ijsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_run   (head_run),
    .empty      (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[sv/ijsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ijsd_checker
// Port-level checks for the decoder output channel.
// ----------------------------------------------------------------------------
module ijsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  // Nothing is left in flight across a reset.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");

  // A stalled beat keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output beat changed");

  // The bytes of one run leave without gaps.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside an output run");

  // No output beat appears in the first cycle after reset.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("output beat without input");

endmodule

bind iso2022jp3_to_sjis_decoder ijsd_checker u_ijsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[test/tb_iso2022jp3_to_sjis_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso2022jp3_to_sjis_decoder
// Feeds ISO-2022-JP-3 byte streams into the decoder and checks every
// Shift_JIS beat against a cycle-free software predictor of the converter.
// A short directed stream covers the escape sequences and corner cases, then
// random mode runs, broken escapes and noise follow, with random gaps on the
// input side and random back-pressure on the output side.
// ----------------------------------------------------------------------------
module tb_iso2022jp3_to_sjis_decoder;
  import ijsd_pkg::*;

  localparam int RANDOM_BYTES = 290;
  localparam int TAIL_ITEMS   = 40;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         drain;
  } jis_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       raw;
    logic       last_of_run;
  } sjis_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [0:0] out_tuser;
  logic       out_tlast;

  iso2022jp3_to_sjis_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jis_item_t  jis_q[$];
  sjis_beat_t sjis_q[$];
  int         mismatches = 0;
  int         beat_cnt = 0;
  int         rand_cnt = 0;
  logic       in_taken = 1'b0;
  int         in_gap = 0;
  int         out_stall = 0;

  // Predictor state of the converter.
  logic [2:0] cur_mode = MODE_ASCII;
  logic [1:0] esc_cnt = 2'd0;
  logic [7:0] esc_b1;
  logic [7:0] esc_b2;
  logic [7:0] lead_byte;
  logic       lead_pend = 1'b0;
  sjis_beat_t run_buf[MAX_RES];
  int         run_n;

  function automatic bit is_graphic(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

  // Returns {ok, lead, trail} for a JIS row/column pair.
  function automatic logic [16:0] jis_to_sjis(input logic [7:0] row, input logic [7:0] col,
                                              input bit plane2);
    int hi;
    int lo;
    hi = int'(row);
    lo = int'(col);
    if (!is_graphic(row) || !is_graphic(col)) return '0;
    if (plane2) begin
      if (hi == 'h21 || (hi >= 'h23 && hi <= 'h25)) begin
        hi += ROW_OFS_A;
      end else if (hi == 'h28 || (hi >= 'h2c && hi <= 'h2f)) begin
        hi += ROW_OFS_B;
      end else if (hi >= 'h6e) begin
        hi += ROW_OFS_C;
      end else begin
        return '0;
      end
    end
    lo += (hi % 2 == 1) ? TRAIL_ODD : TRAIL_EVEN;
    if (lo >= TRAIL_GAP) lo++;
    hi = (hi - PRINT_LO) / 2 + LEAD_BASE;
    if (hi > LEAD_LIMIT) hi += LEAD_GAP;
    return {1'b1, 8'(hi), 8'(lo)};
  endfunction

  task automatic emit(input logic [7:0] b, input logic raw);
    if (run_n < MAX_RES) begin
      run_buf[run_n] = '{data: b, raw: raw, last_of_run: 1'b0};
      run_n++;
    end
  endtask

  task automatic reset_decoder();
    cur_mode  = MODE_ASCII;
    esc_cnt   = 2'd0;
    lead_pend = 1'b0;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [16:0] code;
    if (lead_pend) begin
      // A pending lead takes any byte as its trail.
      lead_pend = 1'b0;
      if (cur_mode == MODE_X0212) begin
        emit(lead_byte, 1'b1);
        emit(b, 1'b1);
      end else begin
        code = jis_to_sjis(lead_byte, b, cur_mode == MODE_MEN2);
        if (!code[16]) begin
          emit(BYTE_QMARK, 1'b0);
        end else begin
          emit(code[15:8], 1'b0);
          emit(code[7:0], 1'b0);
        end
      end
    end else if (b == BYTE_ESC) begin
      esc_cnt = 2'd1;
    end else if (b == BYTE_SI && cur_mode == MODE_KANA) begin
      cur_mode = MODE_ROMAN;
    end else if (b == BYTE_SO && cur_mode == MODE_ROMAN) begin
      cur_mode = MODE_KANA;
    end else if (is_graphic(b) && cur_mode == MODE_KANA) begin
      emit(b | KANA_BIT, 1'b0);
    end else if (is_graphic(b) && cur_mode >= MODE_MEN1 && cur_mode <= MODE_X0212) begin
      lead_byte = b;
      lead_pend = 1'b1;
    end else begin
      emit(b, 1'b0);
    end
  endtask

  // A failed escape goes out as ESC followed by its held bytes taken as data.
  task automatic flush_escape();
    int n;
    n = int'(esc_cnt);
    esc_cnt = 2'd0;
    if (n != 0) begin
      emit(BYTE_ESC, 1'b0);
      if (n > 1) decode_byte(esc_b1);
      if (n > 2) decode_byte(esc_b2);
    end
  endtask

  task automatic extend_escape(input logic [7:0] b, output bit took);
    took = 1'b1;
    if (esc_cnt == 2'd1 && (b == BYTE_DOLLAR || b == BYTE_LPAREN)) begin
      esc_b1  = b;
      esc_cnt = 2'd2;
    end else if (esc_cnt == 2'd2 && esc_b1 == BYTE_DOLLAR && (b == BYTE_AT || b == BYTE_B)) begin
      cur_mode = MODE_X0208;
      esc_cnt  = 2'd0;
    end else if (esc_cnt == 2'd2 && esc_b1 == BYTE_DOLLAR && b == BYTE_LPAREN) begin
      esc_b2  = b;
      esc_cnt = 2'd3;
    end else if (esc_cnt == 2'd2 && esc_b1 == BYTE_LPAREN &&
                 (b == BYTE_B || b == BYTE_J || b == BYTE_I)) begin
      cur_mode = (b == BYTE_B) ? MODE_ASCII : (b == BYTE_J) ? MODE_ROMAN : MODE_KANA;
      esc_cnt  = 2'd0;
    end else if (esc_cnt == 2'd3 && (b == BYTE_O || b == BYTE_P || b == BYTE_D)) begin
      cur_mode = (b == BYTE_O) ? MODE_MEN1 : (b == BYTE_P) ? MODE_MEN2 : MODE_X0212;
      esc_cnt  = 2'd0;
    end else begin
      took = 1'b0;
    end
  endtask

  task automatic predict_sjis(input logic [7:0] b, input logic eos);
    bit took;
    run_n = 0;
    if (esc_cnt != 2'd0) begin
      extend_escape(b, took);
      if (!took) begin
        flush_escape();
        decode_byte(b);
      end
    end else begin
      decode_byte(b);
    end
    if (eos) begin
      flush_escape();
      reset_decoder();
    end
    for (int i = 0; i < run_n; i++) begin
      if (i == run_n - 1) run_buf[i].last_of_run = 1'b1;
      sjis_q.push_back(run_buf[i]);
    end
  endtask

  // Stimulus construction.
  task automatic push_item(input logic [7:0] b, input logic eos);
    jis_q.push_back('{b: b, eos: eos, drain: 1'b0});
  endtask

  task automatic push_drain();
    jis_q.push_back('{b: 8'h00, eos: 1'b0, drain: 1'b1});
  endtask

  task automatic push_rand(input logic [7:0] b);
    push_item(b, $urandom_range(0, 59) == 0);
    rand_cnt++;
  endtask

  task automatic push_escape(input logic [2:0] m);
    push_rand(BYTE_ESC);
    case (m)
      MODE_ROMAN: begin
        push_rand(BYTE_LPAREN);
        push_rand(BYTE_J);
      end
      MODE_KANA: begin
        push_rand(BYTE_LPAREN);
        push_rand(BYTE_I);
      end
      MODE_X0208: begin
        push_rand(BYTE_DOLLAR);
        push_rand($urandom_range(0, 1) ? BYTE_AT : BYTE_B);
      end
      MODE_MEN1, MODE_MEN2, MODE_X0212: begin
        push_rand(BYTE_DOLLAR);
        push_rand(BYTE_LPAREN);
        push_rand((m == MODE_MEN1) ? BYTE_O : (m == MODE_MEN2) ? BYTE_P : BYTE_D);
      end
      default: begin
        push_rand(BYTE_LPAREN);
        push_rand(BYTE_B);
      end
    endcase
  endtask

  task automatic push_char(input logic [2:0] m);
    logic [7:0] row;
    int pick;
    pick = $urandom_range(0, 19);
    if (m >= MODE_MEN1 && m <= MODE_X0212) begin
      if (pick < 2) begin
        push_rand($urandom_range(0, 1) ? 8'h0a : 8'h20);
      end else begin
        row = 8'($urandom_range(PRINT_LO, PRINT_HI));
        // Plane 2 only maps a few rows; favor them.
        if (m == MODE_MEN2 && pick < 14) begin
          case ($urandom_range(0, 2))
            0:       row = 8'($urandom_range(8'h23, 8'h25));
            1:       row = 8'($urandom_range(8'h2c, 8'h2f));
            default: row = 8'($urandom_range(8'h6e, 8'h7e));
          endcase
        end
        push_rand(row);
        if (pick < 18) begin
          push_rand(8'($urandom_range(PRINT_LO, PRINT_HI)));
        end else begin
          push_rand(8'($urandom_range(0, 255)));
        end
      end
    end else if (pick < 3 && m != MODE_ASCII) begin
      push_rand($urandom_range(0, 1) ? BYTE_SI : BYTE_SO);
    end else if (pick < 5) begin
      push_rand(8'($urandom_range(0, 8'h20)));
    end else begin
      push_rand(8'($urandom_range(PRINT_LO, PRINT_HI)));
    end
  endtask

  task automatic push_random_run();
    logic [2:0] m;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      repeat ($urandom_range(1, 6)) push_rand(8'($urandom_range(0, 255)));
    end else if (sel == 1) begin
      // Escape that breaks off at a random point.
      push_rand(BYTE_ESC);
      case ($urandom_range(0, 3))
        0: push_rand(8'($urandom_range(0, 255)));
        1: begin
          push_rand(BYTE_DOLLAR);
          push_rand(8'($urandom_range(0, 255)));
        end
        2: begin
          push_rand(BYTE_LPAREN);
          push_rand(8'($urandom_range(0, 255)));
        end
        default: begin
          push_rand(BYTE_DOLLAR);
          push_rand(BYTE_LPAREN);
          push_rand(8'($urandom_range(0, 255)));
        end
      endcase
    end else begin
      m = 3'($urandom_range(MODE_ASCII, MODE_X0212));
      push_escape(m);
      repeat ($urandom_range(1, 8)) push_char(m);
    end
  endtask

  task automatic note_mismatch(input sjis_beat_t want, input bit have_want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (have_want) begin
        $display("%0t: out beat mismatch: expected %02h raw %0b last %0b, got %02h raw %0b last %0b",
                 $realtime, want.data, want.raw, want.last_of_run,
                 out_tdata, out_tuser[0], out_tlast);
      end else begin
        $display("%0t: unexpected out beat: byte %02h raw %0b last %0b",
                 $realtime, out_tdata, out_tuser[0], out_tlast);
      end
    end
  endtask

  // Input driver: holds a beat until it is taken, then pops the next one.
  always @(negedge clk) begin
    jis_item_t nxt;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (jis_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (jis_q[0].drain) begin
        // Hold off until every expected output beat has arrived.
        in_tvalid <= 1'b0;
        if (sjis_q.size() == 0) void'(jis_q.pop_front());
      end else begin
        nxt = jis_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.b;
        in_tlast  <= nxt.eos;
        if (jis_q.size() > TAIL_ITEMS && (beat_cnt / 40) % 3 != 1 &&
            $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 16);
        end
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall  <= out_stall - 1;
      end else begin
        out_tready <= 1'b1;
        if (jis_q.size() > TAIL_ITEMS && (beat_cnt / 40) % 3 != 2 &&
            $urandom_range(0, 9) == 0) begin
          out_stall <= $urandom_range(1, 16);
        end
      end
    end
  end

  // Monitor: predicts on accepted input beats, checks accepted output beats.
  always @(posedge clk) begin
    sjis_beat_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        predict_sjis(in_tdata, in_tlast);
        beat_cnt++;
      end
      if (out_tvalid && out_tready) begin
        if (sjis_q.size() == 0) begin
          want = '0;
          note_mismatch(want, 1'b0);
        end else begin
          want = sjis_q.pop_front();
          if (out_tdata !== want.data || out_tuser[0] !== want.raw ||
              out_tlast !== want.last_of_run) begin
            note_mismatch(want, 1'b1);
          end
        end
      end
    end
  end

  initial begin
    // Directed stream: byte extremes, switches to kana, roman, plane 2 and X 0212, and the corner cases.
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(BYTE_SI, 1'b0);       // SI outside the X 0201 modes passes through
    push_item(BYTE_ESC, 1'b0);
    push_item(BYTE_LPAREN, 1'b0);
    push_item(BYTE_I, 1'b0);
    push_item(PRINT_HI, 1'b0);      // kana gets bit 7 set
    push_item(BYTE_SI, 1'b0);
    push_item(BYTE_SO, 1'b0);
    push_item(BYTE_ESC, 1'b0);
    push_item(BYTE_DOLLAR, 1'b0);
    push_item(BYTE_LPAREN, 1'b0);
    push_item(BYTE_P, 1'b0);
    push_item(8'h22, 1'b0);         // plane 2 row without a mapping
    push_item(8'h30, 1'b0);
    push_item(8'h6e, 1'b0);         // lead byte; the ESC after it arrives as a trail byte
    push_item(BYTE_ESC, 1'b0);
    push_item(BYTE_ESC, 1'b0);
    push_item(BYTE_DOLLAR, 1'b0);
    push_item(BYTE_LPAREN, 1'b0);
    push_item(BYTE_D, 1'b0);
    push_item(BYTE_ESC, 1'b0);      // broken escape replayed into X 0212 pairs
    push_item(BYTE_DOLLAR, 1'b0);
    push_item(8'h58, 1'b0);
    push_item(8'h41, 1'b1);         // lone lead at end of stream is dropped
    push_item(BYTE_ESC, 1'b0);
    push_item(BYTE_DOLLAR, 1'b1);   // held escape flushed at end of stream
    push_drain();
    while (rand_cnt < RANDOM_BYTES) begin
      push_random_run();
      if (rand_cnt >= RANDOM_BYTES / 2 && rand_cnt < RANDOM_BYTES / 2 + 10) push_drain();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    @(posedge clk);
    while (jis_q.size() != 0 || in_tvalid) @(posedge clk);
    while (sjis_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && sjis_q.size() == 0) begin
      $display("tb_iso2022jp3_to_sjis_decoder: PASS");
    end else begin
      $display("tb_iso2022jp3_to_sjis_decoder: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_iso2022jp3_to_sjis_decoder: FAIL");
    $finish;
  end

endmodule
